// ----- hw/rtl/ckr_pkg.sv -----
// Shared types, constants and helpers for the CAN key chunk reassembler.
// No dependencies; every other file in hw/rtl except ckr_ram uses this package.
`timescale 1ns / 1ps

package ckr_pkg;

  localparam int CHUNK_BYTES     = 8;
  localparam int CHUNK_COUNT     = 8;
  localparam int COMPONENT_WORDS = 4;

  localparam int DATA_W    = 64;
  localparam int ID_W      = 29;
  localparam int CHUNK_W   = 3;   // chunk number field, ID bits 8-10
  localparam int SLOT_COUNT = 4;  // three stored keys plus one assembly slot
  localparam int SLOT_W    = 2;
  localparam int RAM_AW    = SLOT_W + CHUNK_W;
  localparam int RAM_DEPTH = SLOT_COUNT * (1 << CHUNK_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  localparam logic [7:0] CHUNK_MASK = 8'((1 << CHUNK_COUNT) - 1);
  localparam logic [3:0] LEN_CHUNK  = 4'(CHUNK_BYTES);
  localparam logic [3:0] COUNT_LIM  = 4'(CHUNK_COUNT);
  localparam logic [3:0] COMP_LIM   = 4'(COMPONENT_WORDS);
  localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(CHUNK_COUNT - 1);

  // commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // key types
  localparam logic [1:0] KEY_PACK = 2'd0;
  localparam logic [1:0] KEY_APP  = 2'd1;
  localparam logic [1:0] KEY_COMP = 2'd2;

  // ack status
  localparam logic [1:0] ACK_OK   = 2'd0;
  localparam logic [1:0] ACK_SEQ  = 2'd1;
  localparam logic [1:0] ACK_CSUM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PACK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_APP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [7:0]  pack_match;
    logic [7:0]  app_match;
    logic [7:0]  comp_match;
    logic [7:0]  status_match;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   can_id;
    logic [DATA_W-1:0] frame_data;
    logic [3:0]        frame_length;
    logic [1:0]        key_select;
    logic [2:0]        word_index;
  } item_t;

  // result fields except the read word, which comes from the RAM output register
  typedef struct packed {
    logic       accepted;
    logic       ack_valid;
    logic [1:0] ack_key_type;
    logic [2:0] ack_chunk;
    logic [1:0] ack_status;
    logic       key_stored;
    logic [1:0] stored_type;
    logic       all_valid;
    logic       save_request;
    logic       timed_out;
    logic       read_ok;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } ram_wr_t;

  function automatic logic [7:0] byte_xor(input logic [DATA_W-1:0] w);
    logic [7:0] x;
    x = '0;
    for (int i = 0; i < 8; i++) begin
      x = x ^ w[8*i +: 8];
    end
    return x;
  endfunction

endpackage

// ----- hw/rtl/ckr_in_if.sv -----
// Input channel of the key chunk reassembler: valid/ready plus item fields.
// Depends on ckr_pkg.
`timescale 1ns / 1ps

interface ckr_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [ckr_pkg::ID_W-1:0]    can_id;
  logic [ckr_pkg::DATA_W-1:0]  frame_data;
  logic [3:0]                  frame_length;
  logic [1:0]                  key_select;
  logic [2:0]                  word_index;

  modport source(output valid, cmd, can_id, frame_data, frame_length, key_select,
                 word_index, input ready);
  modport sink(input valid, cmd, can_id, frame_data, frame_length, key_select,
               word_index, output ready);
endinterface

// ----- hw/rtl/ckr_out_if.sv -----
// Result channel of the key chunk reassembler: valid/ready plus result fields.
// Depends on ckr_pkg.
`timescale 1ns / 1ps

interface ckr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        ack_valid;
  logic [1:0]                  ack_key_type;
  logic [2:0]                  ack_chunk;
  logic [1:0]                  ack_status;
  logic                        key_stored;
  logic [1:0]                  stored_type;
  logic                        all_valid;
  logic                        save_request;
  logic                        timed_out;
  logic [ckr_pkg::DATA_W-1:0]  read_word;
  logic                        read_ok;

  modport source(output valid, accepted, ack_valid, ack_key_type, ack_chunk, ack_status,
                 key_stored, stored_type, all_valid, save_request, timed_out,
                 read_word, read_ok, input ready);
  modport sink(input valid, accepted, ack_valid, ack_key_type, ack_chunk, ack_status,
               key_stored, stored_type, all_valid, save_request, timed_out,
               read_word, read_ok, output ready);
endinterface

// ----- hw/rtl/ckr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ckr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ckr_cfg.sv -----
// Configuration register file: four ID match bytes and the idle timeout.
// Depends on ckr_pkg.
`timescale 1ns / 1ps

module ckr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ckr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ckr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ckr_pkg::cfg_t                     cfg
);

  ckr_pkg::cfg_t cfg_r;
  ckr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ckr_pkg::CFG_PACK:    cfg_nxt.pack_match   = cfg_wdata[7:0];
        ckr_pkg::CFG_APP:     cfg_nxt.app_match    = cfg_wdata[7:0];
        ckr_pkg::CFG_COMP:    cfg_nxt.comp_match   = cfg_wdata[7:0];
        ckr_pkg::CFG_STATUS:  cfg_nxt.status_match = cfg_wdata[7:0];
        ckr_pkg::CFG_TIMEOUT: cfg_nxt.timeout      = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pack_match   <= '0;
      cfg_r.app_match    <= '0;
      cfg_r.comp_match   <= '0;
      cfg_r.status_match <= '0;
      cfg_r.timeout      <= ckr_pkg::TIMEOUT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/ckr_asm.sv -----
// Assembly state and per-item decision logic: bitmap, XOR, idle timer,
// key valid flags and the slot map into the key RAM. Depends on ckr_pkg.
`timescale 1ns / 1ps

module ckr_asm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ckr_pkg::cfg_t                       cfg,
  input  logic                                advance,
  input  ckr_pkg::item_t                      item,
  output ckr_pkg::res_t                       res,
  output ckr_pkg::ram_wr_t                    ram_wr,
  output logic [ckr_pkg::RAM_AW-1:0]          ram_raddr
);

  // Key RAM holds four slots of eight words. Each key type points at the slot
  // with its stored key; the slot nobody points at collects the open assembly,
  // so a pass only swaps pointers.
  logic                         active_r, active_nxt;
  logic [1:0]                   atype_r, atype_nxt;
  logic [7:0]                   bitmap_r, bitmap_nxt;
  logic [7:0]                   xor_r, xor_nxt;
  logic [15:0]                  idle_r, idle_nxt;
  logic [2:0]                   key_valid_r, key_valid_nxt;
  logic [ckr_pkg::SLOT_W-1:0]   ptr_r [3];
  logic [ckr_pkg::SLOT_W-1:0]   ptr_nxt [3];

  logic [7:0]                   base;
  logic [ckr_pkg::CHUNK_W-1:0]  chunk;
  logic                         is_key, is_status;
  logic [1:0]                   ktype;
  logic                         restart, dup, full;
  logic [7:0]                   bitmap_eff, bitmap_new, xor_eff, xor_new;
  logic [ckr_pkg::SLOT_W-1:0]   free_slot, rd_slot;
  logic [3:0]                   kv4;
  logic                         rd_ok;

  always_comb begin
    active_nxt    = active_r;
    atype_nxt     = atype_r;
    bitmap_nxt    = bitmap_r;
    xor_nxt       = xor_r;
    idle_nxt      = idle_r;
    key_valid_nxt = key_valid_r;
    for (int t = 0; t < 3; t++) begin
      ptr_nxt[t] = ptr_r[t];
    end
    res = '0;

    base  = item.can_id[7:0];
    chunk = item.can_id[10:8];
    is_key    = 1'b1;
    is_status = 1'b0;
    ktype     = ckr_pkg::KEY_PACK;
    if (base == cfg.pack_match) begin
      ktype = ckr_pkg::KEY_PACK;
    end else if (base == cfg.app_match) begin
      ktype = ckr_pkg::KEY_APP;
    end else if (base == cfg.comp_match) begin
      ktype = ckr_pkg::KEY_COMP;
    end else begin
      is_key    = 1'b0;
      is_status = (base == cfg.status_match);
    end

    restart    = !active_r || (atype_r != ktype);
    bitmap_eff = restart ? 8'd0 : bitmap_r;
    xor_eff    = restart ? 8'd0 : xor_r;
    dup        = bitmap_eff[chunk];
    bitmap_new = bitmap_eff | (8'd1 << chunk);
    xor_new    = xor_eff ^ ckr_pkg::byte_xor(item.frame_data);
    full       = ((bitmap_new & ckr_pkg::CHUNK_MASK) == ckr_pkg::CHUNK_MASK);

    // slots 0..3 are all distinct, so the spare one is the XOR of the others
    free_slot = ptr_r[0] ^ ptr_r[1] ^ ptr_r[2];
    ram_wr.we   = 1'b0;
    ram_wr.addr = {free_slot, chunk};
    ram_wr.data = item.frame_data;

    kv4   = {1'b0, key_valid_r};
    rd_ok = (item.key_select != 2'd3) && kv4[item.key_select] &&
            ({1'b0, item.word_index} < ckr_pkg::COUNT_LIM) &&
            !(item.key_select == ckr_pkg::KEY_COMP &&
              {1'b0, item.word_index} >= ckr_pkg::COMP_LIM);
    case (item.key_select)
      ckr_pkg::KEY_PACK: rd_slot = ptr_r[0];
      ckr_pkg::KEY_APP:  rd_slot = ptr_r[1];
      ckr_pkg::KEY_COMP: rd_slot = ptr_r[2];
      default:           rd_slot = '0;
    endcase
    ram_raddr = {rd_slot, item.word_index};

    case (item.cmd)
      ckr_pkg::CMD_FRAME: begin
        if (is_key) begin
          if (item.frame_length == ckr_pkg::LEN_CHUNK) begin
            res.ack_valid    = 1'b1;
            res.ack_key_type = ktype;
            res.ack_chunk    = chunk;
            if ({1'b0, chunk} >= ckr_pkg::COUNT_LIM) begin
              res.ack_status = ckr_pkg::ACK_SEQ;
            end else begin
              res.accepted = 1'b1;
              active_nxt   = 1'b1;
              atype_nxt    = ktype;
              bitmap_nxt   = bitmap_eff;
              xor_nxt      = xor_eff;
              if (restart) begin
                idle_nxt = '0;
              end
              if (!dup) begin
                ram_wr.we  = advance;
                bitmap_nxt = bitmap_new;
                xor_nxt    = xor_new;
                idle_nxt   = '0;
                if (full) begin
                  active_nxt = 1'b0;
                  atype_nxt  = '0;
                  bitmap_nxt = '0;
                  xor_nxt    = '0;
                  if (xor_new != 8'd0) begin
                    res.accepted   = 1'b0;
                    res.ack_chunk  = ckr_pkg::LAST_CHUNK;
                    res.ack_status = ckr_pkg::ACK_CSUM;
                  end else begin
                    key_valid_nxt     = key_valid_r | (3'b001 << ktype);
                    res.key_stored    = 1'b1;
                    res.stored_type   = ktype;
                    res.save_request  = &key_valid_nxt;
                    for (int t = 0; t < 3; t++) begin
                      if (ktype == 2'(t)) begin
                        ptr_nxt[t] = free_slot;
                      end
                    end
                  end
                end
              end
            end
          end
        end else if (is_status) begin
          res.accepted = 1'b1;
        end
      end
      ckr_pkg::CMD_TICK: begin
        if (active_r) begin
          if (idle_r >= cfg.timeout) begin
            active_nxt    = 1'b0;
            atype_nxt     = '0;
            bitmap_nxt    = '0;
            xor_nxt       = '0;
            idle_nxt      = '0;
            res.timed_out = 1'b1;
          end else begin
            idle_nxt = idle_r + 16'd1;
          end
        end
      end
      ckr_pkg::CMD_READ: begin
        res.read_ok = rd_ok;
      end
      default: ;
    endcase

    res.all_valid = &key_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      atype_r     <= '0;
      bitmap_r    <= '0;
      xor_r       <= '0;
      idle_r      <= '0;
      key_valid_r <= '0;
      ptr_r[0]    <= 2'd0;
      ptr_r[1]    <= 2'd1;
      ptr_r[2]    <= 2'd2;
    end else if (advance) begin
      active_r    <= active_nxt;
      atype_r     <= atype_nxt;
      bitmap_r    <= bitmap_nxt;
      xor_r       <= xor_nxt;
      idle_r      <= idle_nxt;
      key_valid_r <= key_valid_nxt;
      for (int t = 0; t < 3; t++) begin
        ptr_r[t] <= ptr_nxt[t];
      end
    end
  end

  a_ptr_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r[0] != ptr_r[1]) && (ptr_r[0] != ptr_r[2]) && (ptr_r[1] != ptr_r[2]))
    else $error("key slot pointers collide");

  a_write_spare_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.we |-> (ram_wr.addr[ckr_pkg::RAM_AW-1 -: ckr_pkg::SLOT_W] != ptr_r[0]) &&
                  (ram_wr.addr[ckr_pkg::RAM_AW-1 -: ckr_pkg::SLOT_W] != ptr_r[1]) &&
                  (ram_wr.addr[ckr_pkg::RAM_AW-1 -: ckr_pkg::SLOT_W] != ptr_r[2]))
    else $error("chunk write hits a stored key slot");

  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((key_valid_r & $past(key_valid_r)) == $past(key_valid_r)))
    else $error("key valid flag dropped");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (bitmap_r == 8'd0) && (xor_r == 8'd0))
    else $error("leftover assembly state while idle");

endmodule

// ----- hw/rtl/can_key_chunk_reassembler.sv -----
// Top level of the CAN key chunk reassembler: stage register, result register
// and handshake. Depends on ckr_pkg, ckr_in_if, ckr_out_if, ckr_cfg, ckr_asm, ckr_ram.
//
//  port       dir   protocol      beat
//  in_ch      in    valid/ready   one command: frame, tick or key read
//  out_ch     out   valid/ready   one result per input beat
//  cfg_*      in    write enable  one register write, no back-pressure
//
// An item passes the stage register and then the result register; one item per
// cycle while out_ch is ready. The key RAM's registered read sets the second stage.
// Synchronous active-low reset clears the pipeline and assembly state; key
// words are undefined until stored. A stalled result holds and only back-
// pressures input once the stage register behind it is also full.
`timescale 1ns / 1ps

module can_key_chunk_reassembler (
  input  logic                            clk,
  input  logic                            rst_n,
  ckr_in_if.sink                          in_ch,
  ckr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ckr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ckr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ckr_pkg::cfg_t    cfg;
  ckr_pkg::item_t   s1_item_r;
  logic             s1_valid_r, s1_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  ckr_pkg::res_t    res_r, res_c;
  ckr_pkg::ram_wr_t ram_wr;
  logic [ckr_pkg::RAM_AW-1:0] ram_raddr;
  logic [ckr_pkg::DATA_W-1:0] ram_rdata;
  logic             out_load, advance, in_accept;

  assign out_load  = !out_valid_r || out_ch.ready;
  assign advance   = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_accept = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_accept || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.cmd          <= in_ch.cmd;
      s1_item_r.can_id       <= in_ch.can_id;
      s1_item_r.frame_data   <= in_ch.frame_data;
      s1_item_r.frame_length <= in_ch.frame_length;
      s1_item_r.key_select   <= in_ch.key_select;
      s1_item_r.word_index   <= in_ch.word_index;
    end
    if (advance) begin
      res_r <= res_c;
    end
  end

  ckr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ckr_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .advance   (advance),
    .item      (s1_item_r),
    .res       (res_c),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr)
  );

  ckr_ram #(
    .WIDTH (ckr_pkg::DATA_W),
    .DEPTH (ckr_pkg::RAM_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_wr.we),
    .waddr (ram_wr.addr),
    .wdata (ram_wr.data),
    .re    (advance),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = res_r.accepted;
  assign out_ch.ack_valid    = res_r.ack_valid;
  assign out_ch.ack_key_type = res_r.ack_key_type;
  assign out_ch.ack_chunk    = res_r.ack_chunk;
  assign out_ch.ack_status   = res_r.ack_status;
  assign out_ch.key_stored   = res_r.key_stored;
  assign out_ch.stored_type  = res_r.stored_type;
  assign out_ch.all_valid    = res_r.all_valid;
  assign out_ch.save_request = res_r.save_request;
  assign out_ch.timed_out    = res_r.timed_out;
  assign out_ch.read_ok      = res_r.read_ok;
  assign out_ch.read_word    = res_r.read_ok ? ram_rdata : '0;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && s1_valid_r) |-> !in_ch.ready)
    else $error("input taken with both stages full");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced item produced no result");

  a_store_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.key_stored) |-> res_r.accepted && res_r.ack_valid &&
                                          (res_r.ack_status == ckr_pkg::ACK_OK))
    else $error("stored key without success ack");

endmodule
